/* sv/trpe_pkg.sv */
// Shared types and constants for the touch report to pointer events block.
// No dependencies; every other file of the block but trpe_if refers to this package.
`default_nettype none

package trpe_pkg;

   localparam int FINGER_SLOTS = 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int GAIN_W       = 5;
   localparam int NUM_STEPS    = 11;
   localparam int STEP_W       = $clog2(NUM_STEPS);

   // report decoding
   localparam logic [7:0]  TOUCH_REPORT = 8'h02;
   localparam logic [7:0]  HARD_MASK    = 8'hF0;
   localparam logic [10:0] POS_MASK     = 11'h7FF;
   localparam int          TOUCH_BIT    = 31;

   localparam logic [7:0] BUTTON_NONE    = 8'h00;
   localparam logic [7:0] BUTTON_LEFT    = 8'h01;
   localparam logic [7:0] BUTTON_RIGHT   = 8'h02;
   localparam logic [7:0] BUTTON_MIDDLE  = 8'h03;
   localparam logic [7:0] BUTTON_FORWARD = 8'h04;
   localparam logic [7:0] BUTTON_BACK    = 8'h08;

   // event kinds
   localparam logic [2:0] EV_RELX   = 3'd0;
   localparam logic [2:0] EV_RELY   = 3'd1;
   localparam logic [2:0] EV_WHEEL  = 3'd2;
   localparam logic [2:0] EV_HWHEEL = 3'd3;
   localparam logic [2:0] EV_KEY    = 3'd4;
   localparam logic [2:0] EV_END    = 3'd5;

   // key ids
   localparam logic [2:0] KEY_LEFT    = 3'd0;
   localparam logic [2:0] KEY_RIGHT   = 3'd1;
   localparam logic [2:0] KEY_MIDDLE  = 3'd2;
   localparam logic [2:0] KEY_BACK    = 3'd3;
   localparam logic [2:0] KEY_FORWARD = 3'd4;
   localparam logic [2:0] KEY_NONE    = 3'd0;
   localparam int         NUM_KEYS    = 5;

   // motion class of a report
   localparam logic [1:0] MOT_NONE   = 2'd0;
   localparam logic [1:0] MOT_REL    = 2'd1;
   localparam logic [1:0] MOT_WHEEL  = 2'd2;
   localparam logic [1:0] MOT_HWHEEL = 2'd3;

   // back-end steps, emitted lowest first; release of key id k is STEP_REL0 + k
   localparam logic [STEP_W-1:0] STEP_RELX   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_RELY   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_MIDDLE = 4'd2;
   localparam logic [STEP_W-1:0] STEP_SCROLL = 4'd3;
   localparam logic [STEP_W-1:0] STEP_REL0   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_REL1   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_REL2   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_REL3   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_REL4   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_PRESS  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_END    = 4'd10;

   typedef logic [NUM_STEPS-1:0] step_mask_type;

   // classified report, passed from front to back
   typedef struct packed {
      logic                handled;
      logic [1:0]          motion;
      logic signed [15:0]  rel_x;
      logic signed [15:0]  rel_y;
      logic                middle;
      logic signed [15:0]  scroll;
      logic [NUM_KEYS-1:0] release_mask;
      logic                press_valid;
      logic [2:0]          press_key;
   } job_type;

endpackage

`default_nettype wire

/* sv/trpe_if.sv */
// Handshake channel interfaces for touch reports and pointer events.
// Depends on nothing; instantiated by the integrating level.
`default_nettype none

interface trpe_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  report_id;
   logic [7:0]  button_bits;
   logic [7:0]  pressure_byte;
   logic [31:0] slot0_word;
   logic [31:0] slot1_word;

   modport source (output valid, output report_id, output button_bits,
                   output pressure_byte, output slot0_word, output slot1_word,
                   input ready);
   modport sink (input valid, input report_id, input button_bits,
                 input pressure_byte, input slot0_word, input slot1_word,
                 output ready);
endinterface

interface trpe_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         event_kind;
   logic [2:0]         key_id;
   logic signed [15:0] event_value;
   logic               last_event;

   modport source (output valid, output event_kind, output key_id,
                   output event_value, output last_event, input ready);
   modport sink (input valid, input event_kind, input key_id,
                 input event_value, input last_event, output ready);
endinterface

`default_nettype wire

/* sv/touch_report_to_pointer_events.sv */
// Touchpad report to pointer events: each report transfer on req_ch yields
// a run of one to nine event transfers on rsp_ch, the last flagged by
// last_event. Reports with an id other than 2 give a single end event of
// value 0 and leave state alone. The front end classifies a report in the
// cycle it is taken and updates finger positions and button latches then,
// so a new report may follow on the very next cycle; classified jobs wait
// in a four-entry queue. The back end sends one event per cycle from a
// registered output stage while rsp_ch is ready, and req_ch stalls only
// when the queue is full. On an idle block a report's job is written into
// the queue, then loaded into the back end's pending-step register, and
// its first event is then registered into the output stage for rsp_ch.
// csr_wdata sets the one-finger motion gain (reset 1); write it only while
// the block is idle.
// Depends on trpe_pkg, trpe_if, trpe_front, trpe_queue and trpe_back.
`default_nettype none

module touch_report_to_pointer_events (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [trpe_pkg::GAIN_W-1:0]  csr_wdata,
   trpe_req_if.sink                          req_ch,
   trpe_rsp_if.source                        rsp_ch
);

   // front to queue
   logic              q_push, q_full;
   trpe_pkg::job_type q_push_data;
   // queue to back
   logic              q_pop, q_not_empty;
   trpe_pkg::job_type q_pop_data;

   // classify, update state, hand the job on
   trpe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   trpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty)
   );

   // emit the job's events in order, end event last
   trpe_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_not_empty),
      .q_data  (q_pop_data),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

/* sv/trpe_front.sv */
// Front end: accepts reports, holds finger and button state, classifies.
// Depends on trpe_pkg and trpe_req_if.
`default_nettype none

module trpe_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [trpe_pkg::GAIN_W-1:0]  csr_wdata,
   trpe_req_if.sink                          req_ch,
   input  wire logic                         q_full,
   output logic                              q_push,
   output trpe_pkg::job_type                 q_data
);

   logic [trpe_pkg::GAIN_W-1:0]   gain_ff;
   logic [10:0]                   prev_x_ff [trpe_pkg::FINGER_SLOTS];
   logic [10:0]                   prev_y_ff [trpe_pkg::FINGER_SLOTS];
   logic [trpe_pkg::FINGER_SLOTS-1:0] prev_p_ff;
   logic [trpe_pkg::NUM_KEYS-1:0] latch_ff, latch_in;

   logic [31:0]        word [trpe_pkg::FINGER_SLOTS];
   logic [trpe_pkg::FINGER_SLOTS-1:0] cp;
   logic [10:0]        cx [trpe_pkg::FINGER_SLOTS];
   logic [10:0]        cy [trpe_pkg::FINGER_SLOTS];
   logic signed [11:0] dx [trpe_pkg::FINGER_SLOTS];
   logic signed [11:0] dy [trpe_pkg::FINGER_SLOTS];
   logic               handled, accept;
   logic               one_finger, two_fingers;
   logic signed [11:0] mx, my;
   logic [17:0]        prod_x, prod_y;
   logic signed [12:0] ddx, ddy, sum_x, sum_y, rnd_x, rnd_y;
   logic signed [11:0] dxm, dym;
   logic               close, small_x, small_y, big_x, big_y;
   logic [trpe_pkg::NUM_KEYS-1:0] press_bit;
   logic [2:0]         press_key;
   logic               press_any;

   function automatic logic signed [15:0] sat16(input logic [17:0] v);
      if (v[17:15] == 3'b000 || v[17:15] == 3'b111) begin
         return v[15:0];
      end else if (v[17]) begin
         return 16'sh8000;
      end else begin
         return 16'sh7FFF;
      end
   endfunction

   assign word[0] = req_ch.slot0_word;
   assign word[1] = req_ch.slot1_word;

   always_comb begin
      for (int i = 0; i < trpe_pkg::FINGER_SLOTS; i++) begin
         cp[i] = word[i][trpe_pkg::TOUCH_BIT];
         cx[i] = word[i][26:16] & trpe_pkg::POS_MASK;
         cy[i] = word[i][10:0] & trpe_pkg::POS_MASK;
         // stored minus current, for the scroll test
         dx[i] = $signed({1'b0, prev_x_ff[i]}) - $signed({1'b0, cx[i]});
         dy[i] = $signed({1'b0, prev_y_ff[i]}) - $signed({1'b0, cy[i]});
      end
   end

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign handled      = req_ch.report_id == trpe_pkg::TOUCH_REPORT;
   assign one_finger   = cp[0] ^ cp[1];
   assign two_fingers  = cp[0] & cp[1];

   // one-finger motion always tracks slot 0
   always_comb begin
      if (prev_p_ff[0] && cp[0]) begin
         mx = -dx[0];
         my = -dy[0];
      end else begin
         mx = -12'sd1;
         my = -12'sd1;
      end
      prod_x = {{6{mx[11]}}, mx} * {13'd0, gain_ff};
      prod_y = {{6{my[11]}}, my} * {13'd0, gain_ff};
   end

   // two-finger scroll detection
   always_comb begin
      ddx   = {dx[0][11], dx[0]} - {dx[1][11], dx[1]};
      ddy   = {dy[0][11], dy[0]} - {dy[1][11], dy[1]};
      sum_x = {dx[0][11], dx[0]} + {dx[1][11], dx[1]};
      sum_y = {dy[0][11], dy[0]} + {dy[1][11], dy[1]};
      rnd_x = sum_x + {12'd0, sum_x[12]};
      rnd_y = sum_y + {12'd0, sum_y[12]};
      dxm   = rnd_x[12:1];
      dym   = rnd_y[12:1];
      close = (ddx == 13'sd0 || ddx == 13'sd1 || ddx == -13'sd1)
           && (ddy == 13'sd0 || ddy == 13'sd1 || ddy == -13'sd1);
      small_x = dxm == 12'sd0 || dxm == 12'sd1 || dxm == -12'sd1;
      small_y = dym == 12'sd0 || dym == 12'sd1 || dym == -12'sd1;
      big_x   = dxm > 12'sd2 || dxm < -12'sd2;
      big_y   = dym > 12'sd2 || dym < -12'sd2;
   end

   // button decode
   always_comb begin
      press_any = 1'b1;
      press_key = trpe_pkg::KEY_NONE;
      case (req_ch.button_bits)
         trpe_pkg::BUTTON_MIDDLE:  press_key = trpe_pkg::KEY_MIDDLE;
         trpe_pkg::BUTTON_LEFT:    press_key = trpe_pkg::KEY_LEFT;
         trpe_pkg::BUTTON_RIGHT:   press_key = trpe_pkg::KEY_RIGHT;
         trpe_pkg::BUTTON_FORWARD: press_key = trpe_pkg::KEY_FORWARD;
         trpe_pkg::BUTTON_BACK:    press_key = trpe_pkg::KEY_BACK;
         default:                  press_any = 1'b0;
      endcase
      press_bit = press_any ? trpe_pkg::NUM_KEYS'(1) << press_key : '0;
      if (req_ch.button_bits == trpe_pkg::BUTTON_NONE) begin
         latch_in = '0;
      end else begin
         latch_in = latch_ff | press_bit;
      end
   end

   always_comb begin
      q_data        = '0;
      q_data.handled = handled;
      q_data.rel_x  = sat16(prod_x);
      q_data.rel_y  = sat16(prod_y);
      q_data.middle = (req_ch.pressure_byte & trpe_pkg::HARD_MASK) == trpe_pkg::HARD_MASK;
      q_data.press_key = press_key;
      if (handled) begin
         if (one_finger) begin
            q_data.motion = trpe_pkg::MOT_REL;
         end else if (two_fingers && prev_p_ff[0] && prev_p_ff[1] && close) begin
            if (small_x && big_y) begin
               q_data.motion = trpe_pkg::MOT_WHEEL;
               q_data.scroll = 16'(-{{4{dym[11]}}, dym});
            end else if (big_x && small_y) begin
               q_data.motion = trpe_pkg::MOT_HWHEEL;
               q_data.scroll = {{4{dxm[11]}}, dxm};
            end
         end
         if (req_ch.button_bits == trpe_pkg::BUTTON_NONE) begin
            q_data.release_mask = latch_ff;
         end
         q_data.press_valid = (press_bit & ~latch_ff) != '0;
      end
   end

   assign q_push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= trpe_pkg::GAIN_W'(1);
         prev_p_ff <= '0;
         latch_ff  <= '0;
         for (int i = 0; i < trpe_pkg::FINGER_SLOTS; i++) begin
            prev_x_ff[i] <= '0;
            prev_y_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            gain_ff <= csr_wdata;
         end
         if (accept && handled) begin
            prev_p_ff <= cp;
            latch_ff  <= latch_in;
            for (int i = 0; i < trpe_pkg::FINGER_SLOTS; i++) begin
               prev_x_ff[i] <= cp[i] ? cx[i] : 11'd0;
               prev_y_ff[i] <= cp[i] ? cy[i] : 11'd0;
            end
         end
      end
   end

endmodule

`default_nettype wire

/* sv/trpe_queue.sv */
// Short job queue between the front and back ends.
// Depends on trpe_pkg.
`default_nettype none

module trpe_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  trpe_pkg::job_type      push_data,
   output logic                   full,
   input  wire logic              pop,
   output trpe_pkg::job_type      pop_data,
   output logic                   not_empty
);

   trpe_pkg::job_type              mem_ff [trpe_pkg::QUEUE_DEPTH];
   logic [trpe_pkg::QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [trpe_pkg::QUEUE_AW:0]    cnt_ff, cnt_in;

   assign full      = cnt_ff == (trpe_pkg::QUEUE_AW+1)'(trpe_pkg::QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (trpe_pkg::QUEUE_AW+1)'(trpe_pkg::QUEUE_DEPTH))
      else $error("queue count past depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

/* sv/trpe_back.sv */
// Back end: walks one queued job, one event transfer per cycle while rsp_ch is ready.
// Depends on trpe_pkg and trpe_rsp_if.
`default_nettype none

module trpe_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           q_valid,
   input  trpe_pkg::job_type   q_data,
   output logic                q_pop,
   trpe_rsp_if.source          rsp_ch
);

   trpe_pkg::job_type            job_ff, job_in;
   trpe_pkg::step_mask_type      pend_ff, pend_in, low, rem, new_mask;
   logic [trpe_pkg::STEP_W-1:0]  sel;
   logic                         out_free, adv;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_kind_ff, rsp_kind_in;
   logic [2:0]         rsp_key_ff, rsp_key_in;
   logic signed [15:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign adv      = out_free && (pend_ff != '0);
   assign low      = pend_ff & (~pend_ff + 1'b1);
   assign rem      = pend_ff & ~low;
   assign q_pop    = q_valid && ((pend_ff == '0) || (adv && rem == '0));

   // steps a fresh job needs
   always_comb begin
      new_mask = '0;
      new_mask[trpe_pkg::STEP_RELX]   = q_data.motion == trpe_pkg::MOT_REL;
      new_mask[trpe_pkg::STEP_RELY]   = q_data.motion == trpe_pkg::MOT_REL;
      new_mask[trpe_pkg::STEP_MIDDLE] = q_data.motion == trpe_pkg::MOT_REL;
      new_mask[trpe_pkg::STEP_SCROLL] = q_data.motion == trpe_pkg::MOT_WHEEL
                                     || q_data.motion == trpe_pkg::MOT_HWHEEL;
      for (int k = 0; k < trpe_pkg::NUM_KEYS; k++) begin
         new_mask[int'(trpe_pkg::STEP_REL0) + k] = q_data.release_mask[k];
      end
      new_mask[trpe_pkg::STEP_PRESS] = q_data.press_valid;
      new_mask[trpe_pkg::STEP_END]   = 1'b1;
   end

   always_comb begin
      pend_in = pend_ff;
      job_in  = job_ff;
      if (q_pop) begin
         pend_in = new_mask;
         job_in  = q_data;
      end else if (adv) begin
         pend_in = rem;
      end
   end

   always_comb begin
      sel = '0;
      for (int i = 0; i < trpe_pkg::NUM_STEPS; i++) begin
         if (low[i]) begin
            sel = trpe_pkg::STEP_W'(i);
         end
      end
   end

   always_comb begin
      rsp_kind_in  = trpe_pkg::EV_KEY;
      rsp_key_in   = trpe_pkg::KEY_NONE;
      rsp_value_in = 16'sd0;
      rsp_last_in  = 1'b0;
      case (sel)
         trpe_pkg::STEP_RELX: begin
            rsp_kind_in  = trpe_pkg::EV_RELX;
            rsp_value_in = job_ff.rel_x;
         end
         trpe_pkg::STEP_RELY: begin
            rsp_kind_in  = trpe_pkg::EV_RELY;
            rsp_value_in = job_ff.rel_y;
         end
         trpe_pkg::STEP_MIDDLE: begin
            rsp_key_in   = trpe_pkg::KEY_MIDDLE;
            rsp_value_in = {15'd0, job_ff.middle};
         end
         trpe_pkg::STEP_SCROLL: begin
            rsp_kind_in  = (job_ff.motion == trpe_pkg::MOT_WHEEL) ?
                           trpe_pkg::EV_WHEEL : trpe_pkg::EV_HWHEEL;
            rsp_value_in = job_ff.scroll;
         end
         trpe_pkg::STEP_REL0, trpe_pkg::STEP_REL1, trpe_pkg::STEP_REL2,
         trpe_pkg::STEP_REL3, trpe_pkg::STEP_REL4: begin
            // releases go out in key id order
            rsp_key_in = 3'(sel - trpe_pkg::STEP_REL0);
         end
         trpe_pkg::STEP_PRESS: begin
            rsp_key_in   = job_ff.press_key;
            rsp_value_in = 16'sd1;
         end
         trpe_pkg::STEP_END: begin
            rsp_kind_in  = trpe_pkg::EV_END;
            rsp_value_in = {15'd0, job_ff.handled};
            rsp_last_in  = 1'b1;
         end
         default: begin
            rsp_kind_in = trpe_pkg::EV_END;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (adv) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_key_ff   <= rsp_key_in;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.event_kind  = rsp_kind_ff;
   assign rsp_ch.key_id      = rsp_key_ff;
   assign rsp_ch.event_value = rsp_value_ff;
   assign rsp_ch.last_event  = rsp_last_ff;

   a_end_pending: assert property (@(posedge clock) disable iff (reset)
      pend_ff != '0 |-> pend_ff[trpe_pkg::STEP_END])
      else $error("job lost its end step");
   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_kind_ff == trpe_pkg::EV_END)))
      else $error("last flag and end kind disagree");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("job taken from empty queue");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("event shown straight after reset");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking bench for touch_report_to_pointer_events: random and directed touch reports,
// a scoreboard class that predicts every pointer event, and tasks for the handshakes.
// Depends on trpe_pkg, trpe_if and the block's RTL.
`timescale 1ns / 1ps

module tb;
   import trpe_pkg::*;

   typedef struct packed {
      logic [7:0]  report_id;
      logic [7:0]  button_bits;
      logic [7:0]  pressure_byte;
      logic [31:0] slot0_word;
      logic [31:0] slot1_word;
   } touch_report_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [2:0]         key;
      logic signed [15:0] value;
      logic               last;
   } pointer_event_type;

   // Tracks finger positions and latched keys as the block should, and keeps the
   // events still owed by the block in arrival order.
   class pointer_event_board;
      logic [GAIN_W-1:0] motion_gain;
      int                prev_x[FINGER_SLOTS];
      int                prev_y[FINGER_SLOTS];
      bit                prev_touch[FINGER_SLOTS];
      logic [NUM_KEYS-1:0] held_keys;
      pointer_event_type pending_events[$];
      int                errors;

      function new();
         motion_gain = 1;
         held_keys = '0;
         errors = 0;
         foreach (prev_x[i]) begin
            prev_x[i] = 0;
            prev_y[i] = 0;
            prev_touch[i] = 0;
         end
      endfunction

      function logic signed [15:0] clip16(int v);
         if (v > 32767) return 16'sh7FFF;
         if (v < -32768) return 16'sh8000;
         return 16'(v);
      endfunction

      function int magnitude(int v);
         return (v < 0) ? -v : v;
      endfunction

      function void add_event(logic [2:0] kind, logic [2:0] key, logic signed [15:0] value,
                              logic last);
         pointer_event_type ev;
         ev.kind = kind;
         ev.key = key;
         ev.value = value;
         ev.last = last;
         pending_events.push_back(ev);
      endfunction

      function void press_key(logic [2:0] key);
         if (held_keys[key]) return;
         held_keys[key] = 1'b1;
         add_event(EV_KEY, key, 16'sd1, 1'b0);
      endfunction

      function void take_report(touch_report_type r);
         int          cx[FINGER_SLOTS];
         int          cy[FINGER_SLOTS];
         bit          cp[FINGER_SLOTS];
         logic [31:0] w;
         int          fingers, mx, my, dx0, dy0, dx1, dy1, dxm, dym;
         if (r.report_id != TOUCH_REPORT) begin
            add_event(EV_END, KEY_NONE, 16'sd0, 1'b1);
            return;
         end
         fingers = 0;
         for (int i = 0; i < FINGER_SLOTS; i++) begin
            w = (i == 0) ? r.slot0_word : r.slot1_word;
            cp[i] = w[TOUCH_BIT];
            cx[i] = int'(w[26:16]);
            cy[i] = int'(w[10:0]);
            if (cp[i]) fingers++;
         end

         if (fingers == 1) begin
            // motion always from slot 0, -1 per axis when either end is missing
            mx = -1;
            my = -1;
            if (prev_touch[0] && cp[0]) begin
               mx = cx[0] - prev_x[0];
               my = cy[0] - prev_y[0];
            end
            add_event(EV_RELX, KEY_NONE, clip16(mx * int'(motion_gain)), 1'b0);
            add_event(EV_RELY, KEY_NONE, clip16(my * int'(motion_gain)), 1'b0);
            add_event(EV_KEY, KEY_MIDDLE,
                      ((r.pressure_byte & HARD_MASK) == HARD_MASK) ? 16'sd1 : 16'sd0, 1'b0);
         end else if (fingers == 2 && prev_touch[0] && prev_touch[1]) begin
            dx0 = prev_x[0] - cx[0];
            dy0 = prev_y[0] - cy[0];
            dx1 = prev_x[1] - cx[1];
            dy1 = prev_y[1] - cy[1];
            if (magnitude(dx0 - dx1) < 2 && magnitude(dy0 - dy1) < 2) begin
               dxm = (dx0 + dx1) / 2;
               dym = (dy0 + dy1) / 2;
               if (magnitude(dxm) < 2 && magnitude(dym) > 2)
                  add_event(EV_WHEEL, KEY_NONE, 16'(-dym), 1'b0);
               else if (magnitude(dxm) > 2 && magnitude(dym) < 2)
                  add_event(EV_HWHEEL, KEY_NONE, 16'(dxm), 1'b0);
            end
         end

         for (int i = 0; i < FINGER_SLOTS; i++) begin
            prev_touch[i] = cp[i];
            prev_x[i] = cp[i] ? cx[i] : 0;
            prev_y[i] = cp[i] ? cy[i] : 0;
         end

         if (r.button_bits == BUTTON_NONE) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (held_keys[k]) begin
                  held_keys[k] = 1'b0;
                  add_event(EV_KEY, 3'(k), 16'sd0, 1'b0);
               end
            end
         end
         if (r.button_bits == BUTTON_MIDDLE) press_key(KEY_MIDDLE);
         else if (r.button_bits == BUTTON_LEFT) press_key(KEY_LEFT);
         else if (r.button_bits == BUTTON_RIGHT) press_key(KEY_RIGHT);
         if (r.button_bits == BUTTON_FORWARD) press_key(KEY_FORWARD);
         if (r.button_bits == BUTTON_BACK) press_key(KEY_BACK);

         add_event(EV_END, KEY_NONE, 16'sd1, 1'b1);
      endfunction

      function void field_check(string field, logic signed [16:0] want,
                                logic signed [16:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void match_event(pointer_event_type got);
         pointer_event_type want;
         if (pending_events.size() == 0) begin
            $display({"%0t ns: event with none expected, expected nothing, ",
                      "got kind %0d key %0d value %0d last %0d"},
                     $time, got.kind, got.key, got.value, got.last);
            errors++;
            return;
         end
         want = pending_events.pop_front();
         field_check("event_kind", want.kind, got.kind);
         field_check("key_id", want.key, got.key);
         field_check("event_value", want.value, got.value);
         field_check("last_event", want.last, got.last);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [GAIN_W-1:0] csr_wdata;

   trpe_req_if req_ch ();
   trpe_rsp_if rsp_ch ();

   touch_report_to_pointer_events u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   pointer_event_board board;

   // idle rates in percent, set per phase
   int send_idle = 33;
   int recv_idle = 61;

   // long receiver stall: raised once by the stimulus, counted down by the receiver
   bit hold_req = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;

   // finger tracks for the random reports
   int track_x[FINGER_SLOTS] = '{100, 400};
   int track_y[FINGER_SLOTS] = '{100, 400};

   logic [7:0] button_codes[5] = '{BUTTON_LEFT, BUTTON_RIGHT, BUTTON_MIDDLE, BUTTON_FORWARD,
                                   BUTTON_BACK};

   always #4 clock = ~clock;

   // Both transfers are recorded at the rising edge; inputs only move on the falling one.
   always @(posedge clock) begin
      touch_report_type  seen;
      pointer_event_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen.report_id = req_ch.report_id;
            seen.button_bits = req_ch.button_bits;
            seen.pressure_byte = req_ch.pressure_byte;
            seen.slot0_word = req_ch.slot0_word;
            seen.slot1_word = req_ch.slot1_word;
            board.take_report(seen);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind = rsp_ch.event_kind;
            got.key = rsp_ch.key_id;
            got.value = rsp_ch.event_value;
            got.last = rsp_ch.last_event;
            board.match_event(got);
         end
      end
   end

   // Event receiver: random back-pressure, plus the one long hold when asked.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_taken) begin
            hold_left = 150;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   // Finger slot word: touch bit, x and y, with the unused bits randomised.
   function logic [31:0] finger(bit touch, int x, int y);
      return {touch, 4'($urandom), 11'(x), 5'($urandom), 11'(y)};
   endfunction

   function touch_report_type make_report(logic [7:0] id, logic [7:0] buttons,
                                          logic [7:0] pressure, logic [31:0] w0,
                                          logic [31:0] w1);
      touch_report_type r;
      r.report_id = id;
      r.button_bits = buttons;
      r.pressure_byte = pressure;
      r.slot0_word = w0;
      r.slot1_word = w1;
      return r;
   endfunction

   // Mostly coherent gestures: both fingers sliding together (scroll), small wander,
   // or a jump anywhere. Slot occupancy and buttons vary freely.
   function touch_report_type random_report();
      touch_report_type r;
      int  shape, mode, step, jx, jy;
      bit  t0, t1;
      logic [7:0] buttons;
      shape = $urandom_range(0, 9);
      t0 = (shape >= 2) && (shape != 5);
      t1 = (shape == 5) || (shape >= 6);
      mode = $urandom_range(0, 9);
      step = int'($urandom_range(3, 40)) * ($urandom_range(0, 1) ? 1 : -1);
      for (int i = 0; i < FINGER_SLOTS; i++) begin
         jx = int'($urandom_range(0, 1));
         jy = int'($urandom_range(0, 1));
         if (mode < 4) begin
            track_x[i] += jx;
            track_y[i] += step + jy;
         end else if (mode < 7) begin
            track_x[i] += step + jx;
            track_y[i] += jy;
         end else if (mode < 9) begin
            track_x[i] += int'($urandom_range(0, 6)) - 3;
            track_y[i] += int'($urandom_range(0, 6)) - 3;
         end else begin
            track_x[i] = $urandom_range(0, 2047);
            track_y[i] = $urandom_range(0, 2047);
         end
         track_x[i] &= 2047;
         track_y[i] &= 2047;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: buttons = BUTTON_NONE;
         4, 5, 6, 7: buttons = button_codes[$urandom_range(0, 4)];
         default: buttons = 8'($urandom);
      endcase
      r = make_report(($urandom_range(0, 9) == 0) ? 8'($urandom) : TOUCH_REPORT, buttons,
                      $urandom_range(0, 1) ? {4'hF, 4'($urandom)} : 8'($urandom),
                      finger(t0, track_x[0], track_y[0]),
                      finger(t1, track_x[1], track_y[1]));
      return r;
   endfunction

   // Offers one report and returns at the rising edge of its transfer; valid stays
   // high so the next call can follow back to back.
   task send_report(touch_report_type r);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.report_id = r.report_id;
      req_ch.button_bits = r.button_bits;
      req_ch.pressure_byte = r.pressure_byte;
      req_ch.slot0_word = r.slot0_word;
      req_ch.slot1_word = r.slot1_word;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drops valid and waits for every owed event.
   task settle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (board.pending_events.size() != 0) @(negedge clock);
   endtask

   task write_gain(logic [GAIN_W-1:0] gain);
      settle();
      csr_we = 1'b1;
      csr_wdata = gain;
      board.motion_gain = gain;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      logic [GAIN_W-1:0] gain;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.report_id = '0;
      req_ch.button_bits = '0;
      req_ch.pressure_byte = '0;
      req_ch.slot0_word = '0;
      req_ch.slot1_word = '0;
      board = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, gain left at its reset value.
      // ignored reports: no button press, no state change
      send_report(make_report(8'h00, BUTTON_LEFT, 8'hFF, finger(1, 10, 10),
                              finger(1, 20, 20)));
      send_report(make_report(8'hFF, BUTTON_NONE, 8'h00, finger(0, 0, 0), finger(0, 0, 0)));
      // no finger, nothing latched
      send_report(make_report(TOUCH_REPORT, BUTTON_NONE, 8'h00, finger(0, 0, 0),
                              finger(0, 2047, 2047)));
      // one finger with nothing stored: -1 per axis; hard press
      send_report(make_report(TOUCH_REPORT, BUTTON_LEFT, 8'hF0, finger(1, 0, 0),
                              finger(0, 0, 0)));
      // full-scale motion both ways; left already latched
      send_report(make_report(TOUCH_REPORT, BUTTON_LEFT, 8'hEF, finger(1, 2047, 2047),
                              finger(0, 0, 0)));
      send_report(make_report(TOUCH_REPORT, BUTTON_RIGHT, 8'hFF, finger(1, 0, 0),
                              finger(0, 0, 0)));
      // finger in slot 1 only: motion still from slot 0, so missing
      send_report(make_report(TOUCH_REPORT, BUTTON_MIDDLE, 8'h0F, finger(0, 0, 0),
                              finger(1, 500, 600)));
      // slot 0 back but its stored position absent
      send_report(make_report(TOUCH_REPORT, BUTTON_FORWARD, 8'hF7, finger(1, 5, 5),
                              finger(0, 0, 0)));
      // zero motion still reported
      send_report(make_report(TOUCH_REPORT, BUTTON_BACK, 8'h7F, finger(1, 5, 5),
                              finger(0, 0, 0)));
      // releases all five keys: the longest run
      send_report(make_report(TOUCH_REPORT, BUTTON_NONE, 8'h80, finger(1, 6, 4),
                              finger(0, 0, 0)));
      // two fingers after a partial touch: only stored
      send_report(make_report(TOUCH_REPORT, 8'h10, 8'h00, finger(1, 100, 100),
                              finger(1, 300, 100)));
      // vertical scroll, then horizontal
      send_report(make_report(TOUCH_REPORT, 8'h05, 8'h11, finger(1, 100, 110),
                              finger(1, 300, 110)));
      send_report(make_report(TOUCH_REPORT, 8'h06, 8'h22, finger(1, 95, 110),
                              finger(1, 295, 110)));
      // fingers apart: no scroll
      send_report(make_report(TOUCH_REPORT, 8'hFF, 8'h33, finger(1, 95, 120),
                              finger(1, 295, 113)));
      // deltas one apart, odd sum: mean truncated toward zero
      send_report(make_report(TOUCH_REPORT, BUTTON_NONE, 8'h44, finger(1, 96, 124),
                              finger(1, 295, 116)));
      // mean of exactly two: no scroll
      send_report(make_report(TOUCH_REPORT, BUTTON_NONE, 8'h55, finger(1, 96, 122),
                              finger(1, 295, 114)));
      // diagonal: no scroll
      send_report(make_report(TOUCH_REPORT, BUTTON_NONE, 8'h66, finger(1, 86, 112),
                              finger(1, 285, 104)));
      // horizontal the other way
      send_report(make_report(TOUCH_REPORT, BUTTON_NONE, 8'h77, finger(1, 90, 112),
                              finger(1, 289, 104)));
      // lift all fingers, press left; an ignored report must not release it
      send_report(make_report(TOUCH_REPORT, BUTTON_LEFT, 8'h00, finger(0, 90, 112),
                              finger(0, 289, 104)));
      send_report(make_report(8'h03, BUTTON_NONE, 8'h00, finger(1, 1, 1), finger(1, 2, 2)));
      send_report(make_report(8'hFD, BUTTON_NONE, 8'hF0, finger(1, 1, 1), finger(0, 2, 2)));
      // two fingers after none: no scroll; left released
      send_report(make_report(TOUCH_REPORT, BUTTON_NONE, 8'h00, finger(1, 50, 50),
                              finger(1, 60, 60)));

      // Random phases, each with a gain written at its start; extremes of the gain field included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: gain = 5'd16;
            1: gain = 5'd1;
            2: gain = 5'd31;
            3: gain = 5'd0;
            4: gain = 5'($urandom_range(1, 16));
            default: gain = 5'd16;
         endcase
         write_gain(gain);
         send_idle = (phase < 2) ? 33 : (phase < 4) ? 61 : 0;
         recv_idle = (phase < 2) ? 61 : (phase < 4) ? 33 : 0;
         for (int n = 0; n < 23; n++) begin
            // the sender keeps going through the long hold, so the queue fills
            if (phase == 5 && n == 4) hold_req = 1'b1;
            send_report(random_report());
         end
      end

      settle();
      repeat (12) @(negedge clock);
      if (board.errors == 0 && board.pending_events.size() == 0)
         $display("touch_report_to_pointer_events test passed");
      else
         $display("touch_report_to_pointer_events test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("touch_report_to_pointer_events test failed");
      $finish;
   end

endmodule
